[sv/btas_pkg.sv]
// Package for the block transfer address sequencer.
// Holds the request/result payload types, controller/datapath command and status types,
// the controller state type, and the list helper functions. No dependencies.
package btas_pkg;

    // Number of architectural registers that may appear in a list
    localparam int NUM_REGS   = 16;
    localparam int LIST_W     = 16;
    localparam int REG_IDX_W  = 4;
    localparam int CNT_W      = $clog2(LIST_W + 1);
    localparam int ADDR_W     = 32;

    localparam logic [REG_IDX_W-1:0] PC_REG     = REG_IDX_W'(15);
    localparam logic [ADDR_W-1:0]    WORD_BYTES = ADDR_W'(4);

    // List bits at or above NUM_REGS are ignored
    localparam logic [LIST_W-1:0] LIST_MASK = (NUM_REGS >= LIST_W) ? {LIST_W{1'b1}} :
        LIST_W'((64'd1 << NUM_REGS) - 64'd1);

    typedef struct packed {
        logic                 func;
        logic                 pre_index;
        logic                 ascending;
        logic                 status_restore_bit;
        logic                 write_back_bit;
        logic [REG_IDX_W-1:0] base_reg;
        logic [LIST_W-1:0]    xfer_list;
        logic [ADDR_W-1:0]    base_value;
    } t_request;

    typedef struct packed {
        logic                 transfer_valid;
        logic                 is_load;
        logic [ADDR_W-1:0]    address;
        logic [REG_IDX_W-1:0] reg_index;
        logic                 pc_plus_eight;
        logic                 write_base;
        logic [ADDR_W-1:0]    base_update;
        logic                 restore_status;
        logic                 advance_pc;
        logic                 last;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_SETUP,
        S_ISSUE
    } t_state;

    typedef struct packed {
        logic capture;
        logic count;
        logic setup;
        logic issue;
    } t_dp_cmd;

    typedef struct packed {
        logic final_issue;
    } t_dp_status;

    function automatic logic [CNT_W-1:0] f_popcount(input logic [LIST_W-1:0] list);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < LIST_W; i++) begin
            n = n + CNT_W'(list[i]);
        end
        return n;
    endfunction

    // Index of the single set bit of a one-hot word (zero when empty)
    function automatic logic [REG_IDX_W-1:0] f_onehot_index(input logic [LIST_W-1:0] onehot);
        logic [REG_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < LIST_W; i++) begin
            if (onehot[i]) begin
                idx = idx | REG_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[sv/btas_ctrl.sv]
// Controller state machine for the block transfer address sequencer.
// Sequences capture, count, setup and one issue step per transfer. Uses btas_pkg.
module btas_ctrl
    import btas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_status.final_issue) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[sv/btas_datapath.sv]
// Datapath for the block transfer address sequencer.
// Holds the request, counts the list, forms addresses and registers each result. Uses btas_pkg.
module btas_datapath
    import btas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_request   i_request,
    output t_dp_status o_status,
    output t_result    o_result,
    output logic       o_result_valid
);

    logic                 r_func;
    logic                 r_pre;
    logic                 r_up;
    logic                 r_sbit;
    logic                 r_wbit;
    logic [REG_IDX_W-1:0] r_base_reg;
    logic [LIST_W-1:0]    r_list;
    logic [ADDR_W-1:0]    r_base;
    logic [CNT_W-1:0]     r_count;
    logic                 r_wb;
    logic                 r_rs;
    logic                 r_adv;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_base_update;
    t_result              r_result;
    logic                 r_result_valid;

    logic [CNT_W-1:0]     n_count;
    logic [ADDR_W-1:0]    span;
    logic [ADDR_W-1:0]    down_off;
    logic [LIST_W-1:0]    low_bit;
    logic [LIST_W-1:0]    rem_after;
    logic [REG_IDX_W-1:0] cur_idx;
    logic                 cur_valid;
    t_result              n_result;

    assign n_count   = f_popcount(r_list);
    assign span      = ADDR_W'({r_count, 2'b00});
    assign down_off  = r_pre ? span : span - WORD_BYTES;

    assign low_bit   = r_list & (~r_list + LIST_W'(1));
    assign rem_after = r_list & ~low_bit;
    assign cur_idx   = f_onehot_index(low_bit);
    assign cur_valid = (r_list != '0);

    assign o_status.final_issue = (rem_after == '0);

    always_comb begin
        n_result                = '0;
        n_result.transfer_valid = cur_valid;
        n_result.is_load        = r_func;
        n_result.address        = cur_valid ? r_addr : '0;
        n_result.reg_index      = cur_idx;
        n_result.pc_plus_eight  = cur_valid && !r_func && (cur_idx == PC_REG);
        n_result.last           = o_status.final_issue;
        if (o_status.final_issue) begin
            n_result.write_base     = r_wb;
            n_result.base_update    = r_base_update;
            n_result.restore_status = r_rs;
            n_result.advance_pc     = r_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_request.func;
            r_pre      <= i_request.pre_index;
            r_up       <= i_request.ascending;
            r_sbit     <= i_request.status_restore_bit;
            r_wbit     <= i_request.write_back_bit;
            r_base_reg <= i_request.base_reg;
            r_list     <= i_request.xfer_list & LIST_MASK;
            r_base     <= i_request.base_value;
        end
        if (i_cmd.count) begin
            r_count <= n_count;
            r_wb    <= r_wbit && !(r_func && r_list[r_base_reg]) && (n_count != '0);
            r_rs    <= r_func && r_sbit && r_list[PC_REG];
            r_adv   <= !(r_func && r_list[PC_REG]);
        end
        if (i_cmd.setup) begin
            r_base_update <= r_up ? r_base + span : r_base - span;
            r_addr        <= r_up ? (r_pre ? r_base + WORD_BYTES : r_base) : r_base - down_off;
        end
        if (i_cmd.issue) begin
            r_list   <= rem_after;
            r_addr   <= r_addr + WORD_BYTES;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.issue;
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

endmodule

[sv/block_transfer_address_sequencer.sv]
// Top level of the block transfer address sequencer (load/store multiple).
// Joins btas_ctrl and btas_datapath; types and helpers come from btas_pkg.
//
//   channel   direction  handshake                 payload
//   request   in         start && !busy            i_request (t_request)
//   result    out        o_result_valid strobe     o_result  (t_result)
//
// A request is taken at an edge with start high and busy low. The controller then
// spends a count step on the register list, a setup step forming the start address
// and written-back base, and one issue step per listed register (one for an empty
// list, at most 16), holding busy until the final issue step; a new request is not
// taken until busy drops. Each result sits on o_result for one cycle with o_result_valid
// high, in the cycle after its issue step; the receiver cannot stall, so no
// backpressure exists.
// Synchronous active-low reset returns the controller to idle and drops the strobe.
module block_transfer_address_sequencer
    import btas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_request,
    output t_result  o_result,
    output logic     o_result_valid
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence the request: capture, count, setup, then one issue step per transfer
    btas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the request, walk the list lowest register first, register each result
    btas_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_request      (i_request),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a request");

    // The final result of a request appears only once the controller is idle again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last |-> !busy)
        else $error("busy still high while final result is shown");

    // A non-final result means more transfers are pending
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last |-> busy)
        else $error("non-final result shown while idle");

    // A result with no transfer only comes from an empty list and is the only one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.transfer_valid |-> o_result.last)
        else $error("empty-list result not marked last");

    // Consecutive transfers of one request step up by one word
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && $past(o_result_valid) && !$past(o_result.last)
        |-> o_result.address == ADDR_W'($past(o_result.address) + WORD_BYTES))
        else $error("transfer address did not advance by one word");
`endif

endmodule
